// ===== hw/rtl/lrm_pkg.sv =====
package lrm_pkg;

    // Coordinate width used inside the rasterizer; port fields stay 16 bits.
    localparam int COORD_BITS = 16;
    localparam int FIELD_BITS = 16;
    localparam int COLOR_BITS = 24;
    localparam int DEC_BITS   = COORD_BITS + 4;
    localparam int INC_BITS   = COORD_BITS + 3;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    // One request as held in the input register.
    typedef struct packed {
        t_op                           operation;
        logic signed [COORD_BITS-1:0]  x0;
        logic signed [COORD_BITS-1:0]  y0;
        logic signed [COORD_BITS-1:0]  x1;
        logic signed [COORD_BITS-1:0]  y1;
        logic        [COLOR_BITS-1:0]  color;
    } t_item;

    // Line state carried from one pixel to the next.
    typedef struct packed {
        logic                          line_active;
        logic                          x_is_major;
        logic                          minor_negative;
        logic signed [COORD_BITS-1:0]  cur_x;
        logic signed [COORD_BITS-1:0]  cur_y;
        logic signed [COORD_BITS-1:0]  major_end;
        logic signed [DEC_BITS-1:0]    decision;
        logic signed [INC_BITS-1:0]    keep_inc;
        logic signed [INC_BITS-1:0]    step_inc;
        logic        [COLOR_BITS-1:0]  held_color;
    } t_state;

    // One emitted pixel.
    typedef struct packed {
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
        logic        [COLOR_BITS-1:0]  color;
        logic                          last;
    } t_pixel;

endpackage

// ===== hw/rtl/lrm_step.sv =====
module lrm_step import lrm_pkg::*; (
    input  t_item  i_item,
    input  t_state i_state,
    output t_state o_state,
    output logic   o_valid,
    output t_pixel o_pixel
);

    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic signed [COORD_BITS:0]   ndx;
    logic signed [COORD_BITS:0]   ndy;
    logic        [COORD_BITS-1:0] adx;
    logic        [COORD_BITS-1:0] ady;
    logic                         x_major;
    logic                         swap;
    logic signed [COORD_BITS:0]   dmin_s;
    logic        [COORD_BITS-1:0] dmaj;
    logic        [COORD_BITS-1:0] admin;
    logic        [COORD_BITS-1:0] dmaj_less_min;
    logic signed [COORD_BITS-1:0] minor_delta;
    logic signed [COORD_BITS-1:0] major_now;
    logic signed [INC_BITS-1:0]   inc;
    t_state                       st;

    // Deltas and their magnitudes for a start request.
    always_comb begin
        dx  = (COORD_BITS+1)'(i_item.x1) - (COORD_BITS+1)'(i_item.x0);
        dy  = (COORD_BITS+1)'(i_item.y1) - (COORD_BITS+1)'(i_item.y0);
        ndx = -dx;
        ndy = -dy;
        adx = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ady = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        x_major = (adx >= ady);
        swap    = x_major ? dx[COORD_BITS] : dy[COORD_BITS];
        dmaj    = x_major ? adx : ady;
        admin   = x_major ? ady : adx;
        if (x_major) begin
            dmin_s = swap ? ndy : dy;
        end else begin
            dmin_s = swap ? ndx : dx;
        end
        dmaj_less_min = dmaj - admin;
    end

    // Next line state and the pixel for either kind of request.
    always_comb begin
        st          = i_state;
        o_valid     = 1'b0;
        o_pixel     = '0;
        minor_delta = i_state.minor_negative ? '1 : COORD_BITS'(1);
        major_now   = '0;
        inc         = '0;
        if (i_item.operation == OP_START) begin
            st.held_color     = i_item.color;
            st.x_is_major     = x_major;
            st.cur_x          = swap ? i_item.x1 : i_item.x0;
            st.cur_y          = swap ? i_item.y1 : i_item.y0;
            if (x_major) begin
                st.major_end = swap ? i_item.x0 : i_item.x1;
            end else begin
                st.major_end = swap ? i_item.y0 : i_item.y1;
            end
            st.minor_negative = dmin_s[COORD_BITS];
            st.decision       = $signed({4'b0, dmaj}) - $signed({3'b0, admin, 1'b0});
            st.keep_inc       = -$signed({2'b0, admin, 1'b0});
            st.step_inc       = $signed({2'b0, dmaj_less_min, 1'b0});
            st.line_active    = (dmaj != '0);
            o_valid           = 1'b1;
            o_pixel.last      = (dmaj == '0);
        end else if (i_state.line_active) begin
            // Positive decision keeps the minor coordinate, otherwise it moves.
            if (i_state.decision > 0) begin
                inc = i_state.keep_inc;
            end else begin
                inc = i_state.step_inc;
                if (i_state.x_is_major) begin
                    st.cur_y = i_state.cur_y + minor_delta;
                end else begin
                    st.cur_x = i_state.cur_x + minor_delta;
                end
            end
            st.decision = i_state.decision + DEC_BITS'(inc);
            if (i_state.x_is_major) begin
                st.cur_x  = i_state.cur_x + COORD_BITS'(1);
                major_now = st.cur_x;
            end else begin
                st.cur_y  = i_state.cur_y + COORD_BITS'(1);
                major_now = st.cur_y;
            end
            o_valid      = 1'b1;
            o_pixel.last = (major_now >= i_state.major_end);
            if (o_pixel.last) begin
                st.line_active = 1'b0;
            end
        end
        o_pixel.x     = st.cur_x;
        o_pixel.y     = st.cur_y;
        o_pixel.color = st.held_color;
        o_state       = st;
    end

endmodule

// ===== hw/rtl/line_rasterizer_midpoint.sv =====
// Midpoint line rasterizer, one pixel per request.
// Input channel: i_in_valid / o_in_stall with the request fields. A start
// request (operation 0) loads two endpoints and a colour and yields the first
// pixel; each step request (operation 1) yields the next pixel of the line.
// A step with no line active is consumed and yields nothing.
// Output channel: o_out_valid / i_out_stall with one pixel per result and
// o_last_pixel marking the far endpoint.
// Path: an accepted request is held in the input register, passes the step
// logic and is shown in the result register.
// Throughput: one request per cycle while the receiver does not stall; the
// per-pixel add, compare and increment sit between the input register and
// the result register, and the line state register feeds back to them.
// When the receiver stalls, the result register holds its pixel and the
// input register holds one further request; o_in_stall rises only when both
// are occupied and the result cannot leave.
// Reset (synchronous, active low) empties both registers and drops any line.
module line_rasterizer_midpoint import lrm_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    input  logic signed [FIELD_BITS-1:0] i_x_start,
    input  logic signed [FIELD_BITS-1:0] i_y_start,
    input  logic signed [FIELD_BITS-1:0] i_x_end,
    input  logic signed [FIELD_BITS-1:0] i_y_end,
    input  logic        [COLOR_BITS-1:0] i_color,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [FIELD_BITS-1:0] o_pixel_x,
    output logic signed [FIELD_BITS-1:0] o_pixel_y,
    output logic        [COLOR_BITS-1:0] o_pixel_color,
    output logic                         o_last_pixel
);

    logic   r_in_valid;
    t_item  r_item;
    t_state r_state;
    logic   r_out_valid;
    t_pixel r_pixel;

    t_state n_state;
    logic   n_valid;
    t_pixel n_pixel;
    logic   advance;
    logic   in_accept;

    // The input register moves on whenever the result register can take data.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    lrm_step u_step (
        .i_item  (r_item),
        .i_state (r_state),
        .o_state (n_state),
        .o_valid (n_valid),
        .o_pixel (n_pixel)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance || !r_in_valid) begin
            r_in_valid <= in_accept;
        end
        if (in_accept) begin
            r_item.operation <= t_op'(i_operation);
            r_item.x0        <= i_x_start[COORD_BITS-1:0];
            r_item.y0        <= i_y_start[COORD_BITS-1:0];
            r_item.x1        <= i_x_end[COORD_BITS-1:0];
            r_item.y1        <= i_y_end[COORD_BITS-1:0];
            r_item.color     <= i_color;
        end
    end

    // Line state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && n_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
        if (advance && r_in_valid && n_valid) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = FIELD_BITS'(r_pixel.x);
    assign o_pixel_y     = FIELD_BITS'(r_pixel.y);
    assign o_pixel_color = r_pixel.color;
    assign o_last_pixel  = r_pixel.last;

    // A start request always yields a pixel.
    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && r_item.operation == OP_START) |=> r_out_valid)
        else $error("start request produced no pixel");

    // A step with no active line yields nothing.
    a_idle_step_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && r_item.operation == OP_STEP && !r_state.line_active)
        |=> !r_out_valid)
        else $error("step without an active line produced a pixel");

    // The last pixel of a line leaves no line active.
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && n_valid && n_pixel.last) |=> !r_state.line_active)
        else $error("line still active after its last pixel");

    // Backpressure only when both registers are occupied and the result is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a held result");

endmodule

// ===== test/line_rasterizer_midpoint_test.sv =====
`timescale 1ns / 1ps

module line_rasterizer_midpoint_test;
    import lrm_pkg::*;

    localparam int RUN_LIMIT   = 200000;
    localparam int ITEM_TARGET = 1450;
    localparam int DRAIN_WAIT  = 10;
    localparam int HOLD_CYCLES = 80;

    // One request waiting to be offered to the rasterizer.
    typedef struct {
        t_op                           op;
        logic signed [FIELD_BITS-1:0]  xs;
        logic signed [FIELD_BITS-1:0]  ys;
        logic signed [FIELD_BITS-1:0]  xe;
        logic signed [FIELD_BITS-1:0]  ye;
        logic        [COLOR_BITS-1:0]  color;
        bit                            wait_drain;
    } t_line_req;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic                         i_operation = 1'b0;
    logic signed [FIELD_BITS-1:0] i_x_start = '0;
    logic signed [FIELD_BITS-1:0] i_y_start = '0;
    logic signed [FIELD_BITS-1:0] i_x_end = '0;
    logic signed [FIELD_BITS-1:0] i_y_end = '0;
    logic        [COLOR_BITS-1:0] i_color = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic signed [FIELD_BITS-1:0] o_pixel_x;
    logic signed [FIELD_BITS-1:0] o_pixel_y;
    logic        [COLOR_BITS-1:0] o_pixel_color;
    logic                         o_last_pixel;

    t_line_req req_q[$];
    t_pixel    expected_pixels[$];
    t_line_req offered_req;
    bit        hold_next = 1'b0;
    int        sent_count = 0;
    int        got_count = 0;
    int        mismatches = 0;
    int        cycle_count = 0;
    int        holdoff_left = 0;
    bit        held_once = 1'b0;

    // Line state of the predictor.
    logic                         ln_active = 1'b0;
    logic                         ln_x_major = 1'b0;
    logic                         ln_minor_neg = 1'b0;
    logic signed [COORD_BITS-1:0] ln_x = '0;
    logic signed [COORD_BITS-1:0] ln_y = '0;
    logic signed [COORD_BITS-1:0] ln_major_end = '0;
    logic signed [DEC_BITS-1:0]   ln_decision = '0;
    logic signed [INC_BITS-1:0]   ln_keep_inc = '0;
    logic signed [INC_BITS-1:0]   ln_step_inc = '0;
    logic        [COLOR_BITS-1:0] ln_color = '0;

    line_rasterizer_midpoint u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_color       (i_color),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

    always #1 i_clk = ~i_clk;

    function automatic int iabs(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Low COORD_BITS of a port field, sign extended.
    function automatic int coord_of(input logic [FIELD_BITS-1:0] v);
        int r;
        r = int'(v) & ((1 << COORD_BITS) - 1);
        if (r & (1 << (COORD_BITS - 1)))
            r -= (1 << COORD_BITS);
        return r;
    endfunction

    // Advance the predicted line by one request; returns 1 when a pixel results.
    function automatic bit rasterize_request(input t_line_req r, output t_pixel px);
        int x0, y0, x1, y1, dx, dy, dmaj, dmin, t, major_now, delta;
        bit is_last;
        px = '0;
        if (r.op == OP_START) begin
            x0 = coord_of(r.xs);
            y0 = coord_of(r.ys);
            x1 = coord_of(r.xe);
            y1 = coord_of(r.ye);
            dx = x1 - x0;
            dy = y1 - y0;
            ln_color = r.color;
            ln_x_major = iabs(dx) >= iabs(dy);
            // Order the endpoints so that the major coordinate ascends.
            if (ln_x_major ? (dx < 0) : (dy < 0)) begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
                dx = -dx;
                dy = -dy;
            end
            ln_x = COORD_BITS'(x0);
            ln_y = COORD_BITS'(y0);
            if (ln_x_major) begin
                ln_major_end = COORD_BITS'(x1);
                dmaj = dx;
                dmin = dy;
            end else begin
                ln_major_end = COORD_BITS'(y1);
                dmaj = dy;
                dmin = dx;
            end
            ln_minor_neg = dmin < 0;
            dmin = iabs(dmin);
            ln_decision = DEC_BITS'(dmaj - 2 * dmin);
            ln_keep_inc = INC_BITS'(-2 * dmin);
            ln_step_inc = INC_BITS'(2 * (dmaj - dmin));
            is_last = (dmaj == 0);
            ln_active = !is_last;
        end else begin
            if (!ln_active)
                return 1'b0;
            delta = ln_minor_neg ? -1 : 1;
            if (ln_decision > 0) begin
                ln_decision = ln_decision + ln_keep_inc;
            end else begin
                ln_decision = ln_decision + ln_step_inc;
                if (ln_x_major)
                    ln_y = COORD_BITS'(int'(ln_y) + delta);
                else
                    ln_x = COORD_BITS'(int'(ln_x) + delta);
            end
            if (ln_x_major) begin
                ln_x = COORD_BITS'(int'(ln_x) + 1);
                major_now = int'(ln_x);
            end else begin
                ln_y = COORD_BITS'(int'(ln_y) + 1);
                major_now = int'(ln_y);
            end
            is_last = major_now >= int'(ln_major_end);
            if (is_last)
                ln_active = 1'b0;
        end
        px.x = ln_x;
        px.y = ln_y;
        px.color = ln_color;
        px.last = is_last;
        return 1'b1;
    endfunction

    task automatic push_req(input t_op op, input int xs, input int ys, input int xe,
                            input int ye, input logic [COLOR_BITS-1:0] color);
        t_line_req r;
        r.op = op;
        r.xs = FIELD_BITS'(xs);
        r.ys = FIELD_BITS'(ys);
        r.xe = FIELD_BITS'(xe);
        r.ye = FIELD_BITS'(ye);
        r.color = color;
        r.wait_drain = hold_next;
        hold_next = 1'b0;
        req_q.push_back(r);
    endtask

    // A step request whose unused fields carry random content.
    task automatic push_step();
        push_req(OP_STEP, $urandom, $urandom, $urandom, $urandom,
                 COLOR_BITS'($urandom));
    endtask

    // A start request followed by a given number of steps.
    task automatic push_line(input int xs, input int ys, input int xe, input int ye,
                             input logic [COLOR_BITS-1:0] color, input int steps);
        push_req(OP_START, xs, ys, xe, ye, color);
        repeat (steps) push_step();
    endtask

    // Stimulus and end of run.
    initial begin : stimulus
        int xs, ys, xe, ye, dmaj, pick, n;
        // Step with no line after reset, then a single-point line and a step after it.
        push_step();
        push_line(5, -7, 5, -7, 24'hFFFFFF, 1);
        // Horizontal line, then a vertical line drawn downwards.
        push_line(-2, 2, 2, 2, 24'h000000, 4);
        push_line(1, 3, 1, -1, 24'h5A5A5A, 4);
        // Diagonal tie drawn right to left, with one step past its end.
        push_line(0, 0, -4, 4, 24'hA5A5A5, 5);
        // Full-range endpoints, cut short by a new start.
        push_line(-32768, -32768, 32767, 32767, 24'hFFFFFF, 2);
        push_line(32767, -32768, -32768, 32767, 24'h000000, 2);
        hold_next = 1'b1;

        while (req_q.size() < ITEM_TARGET) begin
            if (req_q.size() > 800 && req_q.size() < 820)
                hold_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // Short complete line somewhere in the coordinate range.
                xs = $urandom_range(0, 65535 - 128) - 32768 + 64;
                ys = $urandom_range(0, 65535 - 128) - 32768 + 64;
                xe = xs + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 24));
                ye = ys + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 24));
                dmaj = (iabs(xe - xs) > iabs(ye - ys)) ? iabs(xe - xs) : iabs(ye - ys);
                n = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 2) : 0;
                push_line(xs, ys, xe, ye, COLOR_BITS'($urandom), dmaj + n);
            end else if (pick < 85) begin
                // Long line with arbitrary endpoints, abandoned after a few pixels.
                push_line($urandom, $urandom, $urandom, $urandom, COLOR_BITS'($urandom),
                          $urandom_range(0, 5));
            end else begin
                // Loose requests of either kind.
                repeat ($urandom_range(1, 3))
                    push_req(t_op'($urandom_range(0, 1)), $urandom, $urandom,
                             $urandom, $urandom, COLOR_BITS'($urandom));
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || i_in_valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("line_rasterizer_midpoint_test OK");
        end else begin
            $display("line_rasterizer_midpoint_test NOT OK");
        end
        $finish;
    end

    // Request driver: predicts each accepted request and offers the next one.
    always @(posedge i_clk) begin : driver
        bit     offer;
        t_pixel px;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offer = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                if (rasterize_request(offered_req, px))
                    expected_pixels.push_back(px);
                sent_count++;
                offer = 1'b0;
            end
            if (!offer && req_q.size() != 0) begin
                if (!(req_q[0].wait_drain && expected_pixels.size() != 0) &&
                    ((sent_count >= 300 && sent_count < 450) ||
                     $urandom_range(0, 99) >= 11)) begin
                    offered_req = req_q.pop_front();
                    offer = 1'b1;
                    i_operation <= offered_req.op;
                    i_x_start   <= offered_req.xs;
                    i_y_start   <= offered_req.ys;
                    i_x_end     <= offered_req.xe;
                    i_y_end     <= offered_req.ye;
                    i_color     <= offered_req.color;
                end
            end
            i_in_valid <= offer;
        end
    end

    // Pixel monitor: checks each accepted pixel and drives the receiver stall.
    always @(posedge i_clk) begin : monitor
        t_pixel act;
        t_pixel exp_px;
        bit     stall_n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                act.x = o_pixel_x;
                act.y = o_pixel_y;
                act.color = o_pixel_color;
                act.last = o_last_pixel;
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel x=%0d y=%0d color=%06h last=%0d",
                                 act.x, act.y, act.color, act.last);
                end else begin
                    exp_px = expected_pixels.pop_front();
                    if (act !== exp_px) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("pixel %0d mismatch: expected x=%0d y=%0d %s",
                                     got_count, exp_px.x, exp_px.y, "");
                            $display("    expected color=%06h last=%0d",
                                     exp_px.color, exp_px.last);
                            $display("    got x=%0d y=%0d color=%06h last=%0d",
                                     act.x, act.y, act.color, act.last);
                        end
                    end
                end
                got_count++;
            end
            // One long hold-off lets the block fill and stall its input.
            if (holdoff_left > 0) begin
                holdoff_left--;
                stall_n = 1'b1;
            end else if (!held_once && got_count >= 600) begin
                held_once = 1'b1;
                holdoff_left = HOLD_CYCLES;
                stall_n = 1'b1;
            end else if (got_count >= 300 && got_count < 450) begin
                stall_n = 1'b0;
            end else begin
                stall_n = $urandom_range(0, 99) < 11;
            end
            i_out_stall <= stall_n;
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("line_rasterizer_midpoint_test NOT OK");
            $finish;
        end
    end

endmodule
